FILE: src/siph_pkg.sv
// ----------------------------------------------------------------------------
// siph_pkg
// Types, constants and round functions shared by the keyed SipHash-2-4 block.
// ----------------------------------------------------------------------------
package siph_pkg;

    localparam int unsigned SHORT_ID_BYTES = 6;

    localparam logic [63:0] INIT_C0   = 64'h736f6d6570736575;
    localparam logic [63:0] INIT_C1   = 64'h646f72616e646f6d;
    localparam logic [63:0] INIT_C2   = 64'h6c7967656e657261;
    localparam logic [63:0] INIT_C3   = 64'h7465646279746573;
    localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;

    localparam logic [63:0] SHORT_MASK = (SHORT_ID_BYTES >= 8) ? {64{1'b1}} :
        ((64'd1 << (8 * SHORT_ID_BYTES)) - 64'd1);

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = QPTR_W + 1;

    typedef struct packed {
        logic [63:0] msg_word;
        logic [3:0]  word_bytes;
        logic        last_word;
    } t_in;

    typedef struct packed {
        logic [63:0] hash_value;
        logic [47:0] tag_id;
    } t_out;

    typedef enum logic [1:0] {
        KIND_MID,
        KIND_FULL,
        KIND_PART
    } t_kind;

    // classified word as it sits in the queue
    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        t_kind       kind;
    } t_entry;

    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } t_lanes;

    typedef struct packed {
        t_lanes      lanes;
        logic [63:0] block;
    } t_fin_item;

    typedef struct packed {
        logic s1_busy;
        logic s2_busy;
        logic s3_busy;
    } t_fin_stat;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned s);
        return (x << s) | (x >> (64 - s));
    endfunction

    function automatic t_lanes sip_round(input t_lanes l);
        t_lanes r;
        r = l;
        r.v0 = r.v0 + r.v1;
        r.v1 = rotl(r.v1, 13) ^ r.v0;
        r.v0 = rotl(r.v0, 32);
        r.v2 = r.v2 + r.v3;
        r.v3 = rotl(r.v3, 16) ^ r.v2;
        r.v0 = r.v0 + r.v3;
        r.v3 = rotl(r.v3, 21) ^ r.v0;
        r.v2 = r.v2 + r.v1;
        r.v1 = rotl(r.v1, 17) ^ r.v2;
        r.v2 = rotl(r.v2, 32);
        return r;
    endfunction

    function automatic t_lanes sip_round2(input t_lanes l);
        return sip_round(sip_round(l));
    endfunction

    function automatic t_lanes compress(input t_lanes l, input logic [63:0] m);
        t_lanes r;
        r = l;
        r.v3 = r.v3 ^ m;
        r = sip_round2(r);
        r.v0 = r.v0 ^ m;
        return r;
    endfunction

    function automatic t_lanes load_lanes(input logic [63:0] klo, input logic [63:0] khi);
        t_lanes r;
        r.v0 = INIT_C0 ^ klo;
        r.v1 = INIT_C1 ^ khi;
        r.v2 = INIT_C2 ^ klo;
        r.v3 = INIT_C3 ^ khi;
        return r;
    endfunction

endpackage

FILE: src/siphash_short_id.sv
// ----------------------------------------------------------------------------
// siphash_short_id
// Keyed SipHash-2-4 over little-endian 64-bit message words, giving the full
// hash and a short id for each message.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+----------------------
//   in      | input     | i_in_valid / o_in_stall    | i_in_data  (t_in)
//   out     | output    | o_out_valid / i_out_stall  | o_out_data (t_out)
//   cfg     | input     | i_cfg_we, i_cfg_idx        | i_cfg_data (key words)
//
// One word per cycle unless stalled: the core's lane loop runs two SipRounds
// a cycle. A last word goes via queue slot, finalizer input, two round stages
// and output register to o_out_valid; the next message overlaps.
// Reset is synchronous: keys clear, lanes load the init constants, queue
// and finalizer empty. Output stalls back up through the finalizer and the
// four-entry queue to o_in_stall.
// ----------------------------------------------------------------------------
module siphash_short_id (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [siph_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [63:0]                     i_cfg_data,
    input  logic                            i_in_valid,
    input  siph_pkg::t_in                   i_in_data,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    output siph_pkg::t_out                  o_out_data,
    input  logic                            i_out_stall
);
    import siph_pkg::*;

    t_entry    front_entry;
    t_entry    q_head;
    logic      q_full;
    logic      q_valid;
    logic      q_pop;
    logic      fin_ready;
    logic      fin_push;
    t_fin_item fin_item;
    t_fin_stat fin_stat;

    siph_front u_front (
        .i_in    (i_in_data),
        .o_entry (front_entry)
    );

    siph_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    assign o_in_stall = q_full;

    siph_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .i_fin_ready (fin_ready),
        .o_fin_push  (fin_push),
        .o_fin_item  (fin_item)
    );

    siph_final u_final (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (fin_push),
        .i_item      (fin_item),
        .o_ready     (fin_ready),
        .o_stat      (fin_stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("core popped an empty queue");

    a_push_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_push |-> fin_ready)
        else $error("core pushed into a full finalizer");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(fin_stat.s3_busy))
        else $error("result appeared without a message in the last stage");
`endif

endmodule

FILE: src/siph_front.sv
// ----------------------------------------------------------------------------
// siph_front
// Classifies an incoming word: middle word, full last word or partial last
// word, and zeroes the bytes of a partial last word above its count.
// ----------------------------------------------------------------------------
module siph_front (
    input  siph_pkg::t_in    i_in,
    output siph_pkg::t_entry o_entry
);
    import siph_pkg::*;

    logic [3:0]  cnt;
    logic [63:0] masked;

    always_comb begin
        // clamp oversized counts to a full word
        cnt = (i_in.word_bytes > 4'd8) ? 4'd8 : i_in.word_bytes;
        for (int b = 0; b < 8; b++) begin
            masked[b*8 +: 8] = (4'(b) < cnt) ? i_in.msg_word[b*8 +: 8] : 8'd0;
        end
        o_entry.word   = i_in.msg_word;
        o_entry.nbytes = cnt;
        if (!i_in.last_word) begin
            o_entry.kind = KIND_MID;
        end else if (cnt == 4'd8) begin
            o_entry.kind = KIND_FULL;
        end else begin
            o_entry.kind = KIND_PART;
            o_entry.word = masked;
        end
    end

endmodule

FILE: src/siph_queue.sv
// ----------------------------------------------------------------------------
// siph_queue
// Short register queue between the classifier and the compression core.
// ----------------------------------------------------------------------------
module siph_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  siph_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output siph_pkg::t_entry o_head
);
    import siph_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QCNT_W-1:0]   r_count;
    logic [QCNT_W-1:0]   n_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

FILE: src/siph_core.sv
// ----------------------------------------------------------------------------
// siph_core
// Holds the key and four lanes; compresses one queued word per cycle (a last
// word waits for finalizer room), and hands state plus final block to it.
// ----------------------------------------------------------------------------
module siph_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [siph_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [63:0]                       i_cfg_data,
    input  logic                              i_q_valid,
    input  siph_pkg::t_entry                  i_q_head,
    output logic                              o_q_pop,
    input  logic                              i_fin_ready,
    output logic                              o_fin_push,
    output siph_pkg::t_fin_item               o_fin_item
);
    import siph_pkg::*;

    logic [63:0] r_key_low;
    logic [63:0] r_key_high;
    logic [63:0] n_key_low;
    logic [63:0] n_key_high;
    t_lanes      r_lanes;
    t_lanes      n_lanes;
    logic [7:0]  r_total;
    logic [7:0]  n_total;
    t_lanes      packed_lanes;
    logic [7:0]  total_sum;

    always_comb begin
        n_key_low    = r_key_low;
        n_key_high   = r_key_high;
        n_lanes      = r_lanes;
        n_total      = r_total;
        o_q_pop      = 1'b0;
        o_fin_push   = 1'b0;
        packed_lanes = compress(r_lanes, i_q_head.word);
        total_sum    = r_total + 8'd8;
        o_fin_item.lanes = packed_lanes;
        o_fin_item.block = {total_sum, 56'd0};

        case (i_q_head.kind)
            KIND_MID: begin
                o_q_pop = i_q_valid;
                if (i_q_valid) begin
                    n_lanes = packed_lanes;
                    n_total = total_sum;
                end
            end
            KIND_FULL: begin
                o_q_pop    = i_q_valid && i_fin_ready;
                o_fin_push = o_q_pop;
            end
            KIND_PART: begin
                total_sum        = r_total + 8'(i_q_head.nbytes);
                o_fin_item.lanes = r_lanes;
                o_fin_item.block = i_q_head.word | {total_sum, 56'd0};
                o_q_pop          = i_q_valid && i_fin_ready;
                o_fin_push       = o_q_pop;
            end
            default: begin
                o_q_pop = 1'b0;
            end
        endcase

        // a finished message restarts the lanes from the key
        if (o_fin_push) begin
            n_lanes = load_lanes(r_key_low, r_key_high);
            n_total = 8'd0;
        end

        if (i_cfg_we) begin
            if (i_cfg_idx == REG_KEY_LOW) begin
                n_key_low = i_cfg_data;
            end
            if (i_cfg_idx == REG_KEY_HIGH) begin
                n_key_high = i_cfg_data;
            end
            n_lanes = load_lanes(n_key_low, n_key_high);
            n_total = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_lanes    <= load_lanes('0, '0);
            r_total    <= '0;
        end else begin
            r_key_low  <= n_key_low;
            r_key_high <= n_key_high;
            r_lanes    <= n_lanes;
            r_total    <= n_total;
        end
    end

endmodule

FILE: src/siph_final.sv
// ----------------------------------------------------------------------------
// siph_final
// Three-stage finalizer: compress the last block and flip v2, then two
// double rounds, then fold the lanes into the hash and short id.
// ----------------------------------------------------------------------------
module siph_final (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  siph_pkg::t_fin_item  i_item,
    output logic                 o_ready,
    output siph_pkg::t_fin_stat  o_stat,
    output logic                 o_out_valid,
    output siph_pkg::t_out       o_out_data,
    input  logic                 i_out_stall
);
    import siph_pkg::*;

    t_fin_item   r_s1;
    t_lanes      r_s2;
    t_lanes      r_s3;
    logic        r_v1;
    logic        r_v2;
    logic        r_v3;
    logic        r_out_valid;
    t_out        r_out;
    logic        out_free;
    logic        adv1;
    logic        adv2;
    logic        adv3;
    t_lanes      s2_next;
    t_lanes      s3_next;
    t_lanes      out_lanes;
    logic [63:0] hash;

    always_comb begin
        out_free = !r_out_valid || !i_out_stall;
        adv3     = r_v3 && out_free;
        adv2     = r_v2 && (!r_v3 || adv3);
        adv1     = r_v1 && (!r_v2 || adv2);
        o_ready  = !r_v1 || adv1;

        s2_next    = compress(r_s1.lanes, r_s1.block);
        s2_next.v2 = s2_next.v2 ^ FINAL_XOR;
        s3_next    = sip_round2(r_s2);
        out_lanes  = sip_round2(r_s3);
        hash       = out_lanes.v0 ^ out_lanes.v1 ^ out_lanes.v2 ^ out_lanes.v3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_push) begin
                r_v1 <= 1'b1;
            end else if (adv1) begin
                r_v1 <= 1'b0;
            end
            if (adv1) begin
                r_v2 <= 1'b1;
            end else if (adv2) begin
                r_v2 <= 1'b0;
            end
            if (adv2) begin
                r_v3 <= 1'b1;
            end else if (adv3) begin
                r_v3 <= 1'b0;
            end
            if (adv3) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_s1 <= i_item;
        end
        if (adv1) begin
            r_s2 <= s2_next;
        end
        if (adv2) begin
            r_s3 <= s3_next;
        end
        if (adv3) begin
            r_out.hash_value <= hash;
            r_out.tag_id     <= 48'(hash & SHORT_MASK);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;
    assign o_stat.s1_busy = r_v1;
    assign o_stat.s2_busy = r_v2;
    assign o_stat.s3_busy = r_v3;

endmodule
